// ===== rtl/utf8dec_pkg.sv =====
// Package for the UTF-8 sequence decoder: field widths, byte-count type and
// the per-class payload mask and minimum tables.
// No dependencies.
`timescale 1ns / 1ps

package utf8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 31;
  localparam int unsigned CountW = 3;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [CodeW-1:0]  code_t;
  typedef logic [CountW-1:0] seq_len_t;

  // Total byte counts of a sequence
  localparam seq_len_t Len1 = 3'd1;
  localparam seq_len_t Len2 = 3'd2;
  localparam seq_len_t Len3 = 3'd3;
  localparam seq_len_t Len4 = 3'd4;
  localparam seq_len_t Len5 = 3'd5;
  localparam seq_len_t Len6 = 3'd6;

  // Payload mask of a finished sequence by its byte count
  function automatic code_t class_mask(seq_len_t len);
    code_t m;
    case (len)
      Len1:    m = 31'h0000_007F;
      Len2:    m = 31'h0000_07FF;
      Len3:    m = 31'h0000_FFFF;
      Len4:    m = 31'h001F_FFFF;
      Len5:    m = 31'h03FF_FFFF;
      default: m = 31'h7FFF_FFFF;
    endcase
    return m;
  endfunction

  // Smallest value that is not overlong for the byte count
  function automatic code_t class_min(seq_len_t len);
    code_t m;
    case (len)
      Len1:    m = 31'h0000_0000;
      Len2:    m = 31'h0000_0080;
      Len3:    m = 31'h0000_0800;
      Len4:    m = 31'h0001_0000;
      Len5:    m = 31'h0020_0000;
      default: m = 31'h0400_0000;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/utf8dec_if.sv =====
// Handshake interfaces of the UTF-8 sequence decoder: byte input channel
// and decoded result channel. Depends on utf8dec_pkg.
`timescale 1ns / 1ps

interface utf8dec_in_if;
  import utf8dec_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8dec_out_if;
  import utf8dec_pkg::*;
  logic     valid;
  logic     ready;
  code_t    code_point;
  logic     decode_error;
  seq_len_t seq_bytes;

  modport source (output valid, output code_point, output decode_error,
                  output seq_bytes, input ready);
  modport sink   (input valid, input code_point, input decode_error,
                  input seq_bytes, output ready);
endinterface

// ===== rtl/utf8_sequence_decoder.sv =====
// UTF-8 sequence decoder top level, 1 to 6 byte form.
// Depends on utf8dec_pkg and the interfaces in utf8dec_if.sv.
//
// Takes one byte per cycle and gives one result per finished sequence: the
// code point masked to its class, an error flag and the byte count. A byte
// is held in an input register, decoded against the sequence state by a
// short mask/shift/compare path, and a finished result lands in an output
// register, so the last byte of a sequence passes the input register and
// then the output register before its result is presented.
// Throughput is one byte per cycle; the input register and the output
// register let a new byte enter while a result waits to be taken, and the
// block only stalls a byte that finishes a sequence while the output
// register is full and not being read. Stray leads (10xxxxxx, 0xFE, 0xFF)
// open a 6-byte sequence that ends in error; bad continuation bytes are
// still counted.
`timescale 1ns / 1ps

module utf8_sequence_decoder (
  input logic          clk,
  input logic          rst,
  utf8dec_in_if.sink   in_ch,
  utf8dec_out_if.source out_ch
);
  import utf8dec_pkg::*;

  // input register
  logic  in_valid;
  byte_t in_q;

  // sequence state
  seq_len_t bytes_left;
  code_t    accumulator;
  seq_len_t seq_class;
  logic     sticky_error;

  // output register
  logic     out_valid;
  code_t    code_point;
  logic     decode_error;
  seq_len_t seq_bytes;

  // decode path
  seq_len_t bytes_left_next;
  code_t    accumulator_next;
  seq_len_t seq_class_next;
  logic     sticky_error_next;
  logic     finish;
  code_t    value;
  logic     err;
  logic     step;

  always_comb begin
    seq_class_next    = seq_class;
    sticky_error_next = sticky_error;
    if (bytes_left == '0) begin
      sticky_error_next = 1'b0;
      case (in_q) inside
        8'b0???_????: seq_class_next = Len1;
        8'b110?_????: seq_class_next = Len2;
        8'b1110_????: seq_class_next = Len3;
        8'b1111_0???: seq_class_next = Len4;
        8'b1111_10??: seq_class_next = Len5;
        8'b1111_110?: seq_class_next = Len6;
        default: begin
          seq_class_next    = Len6;
          sticky_error_next = 1'b1;
        end
      endcase
      accumulator_next = {{(CodeW-ByteW){1'b0}}, in_q};
      bytes_left_next  = seq_class_next - Len1;
    end else begin
      if (in_q[7:6] != 2'b10) begin
        sticky_error_next = 1'b1;
      end
      accumulator_next = {accumulator[CodeW-7:0], in_q[5:0]};
      bytes_left_next  = bytes_left - 3'd1;
    end
    finish = (bytes_left_next == '0);
    value  = accumulator_next & class_mask(seq_class_next);
    err    = sticky_error_next | (value < class_min(seq_class_next));
  end

  // hold a finishing byte only while the result register is blocked
  assign step        = in_valid & (~finish | ~out_valid | out_ch.ready);
  assign in_ch.ready = ~in_valid | step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      accumulator  <= '0;
      seq_class    <= '0;
      sticky_error <= 1'b0;
    end else if (step) begin
      if (finish) begin
        bytes_left   <= '0;
        accumulator  <= '0;
        seq_class    <= '0;
        sticky_error <= 1'b0;
      end else begin
        bytes_left   <= bytes_left_next;
        accumulator  <= accumulator_next;
        seq_class    <= seq_class_next;
        sticky_error <= sticky_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && finish) begin
      code_point   <= err ? '0 : value;
      decode_error <= err;
      seq_bytes    <= seq_class_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.code_point   = code_point;
  assign out_ch.decode_error = decode_error;
  assign out_ch.seq_bytes    = seq_bytes;

endmodule
